### sv/msh_pkg.sv
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package msh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t vars_t [8];

  typedef struct packed {
    word_t w1;
    word_t w2;
    word_t w10;
    word_t w15;
  } taps_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD0,
    ST_LOAD1,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_t;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_START     = 6'd56;
  localparam logic [5:0] LAST_SLOT     = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [5:0] LAST_LOADED   = 6'd15;
  localparam logic [2:0] LAST_WORD_NUM = 3'd7;

  localparam vars_t INIT_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

### sv/msh_ifs.sv
// ----------------------------------------------------------------------------
// msh_ifs
// Request and digest channels of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

interface msh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       last_of_message;

  modport source (output valid, msg_byte, byte_present, last_of_message, input ready);
  modport sink   (input valid, msg_byte, byte_present, last_of_message, output ready);
endinterface

interface msh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

`default_nettype wire

### sv/msh_round.sv
// ----------------------------------------------------------------------------
// msh_round
// One SHA-256 compression round and the next message schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module msh_round (
  input  msh_pkg::vars_t      vars_i,
  input  msh_pkg::word_t      w_i,
  input  logic [5:0]          round_i,
  input  msh_pkg::taps_t      taps_i,
  output msh_pkg::vars_t      vars_o,
  output msh_pkg::word_t      w_o
);
  import msh_pkg::*;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1  = vars_i[7] + big_sigma1(vars_i[4]) + ch + ROUND_K[round_i] + w_i;
  assign t2  = big_sigma0(vars_i[0]) + maj;

  always_comb begin
    vars_o[0] = t1 + t2;
    vars_o[1] = vars_i[0];
    vars_o[2] = vars_i[1];
    vars_o[3] = vars_i[2];
    vars_o[4] = vars_i[3] + t1;
    vars_o[5] = vars_i[4];
    vars_o[6] = vars_i[5];
    vars_o[7] = vars_i[6];
  end

  assign w_o = small_sigma1(taps_i.w15) + taps_i.w10 + small_sigma0(taps_i.w2) + taps_i.w1;

endmodule

`default_nettype wire

### sv/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 digest of a byte stream, one message byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per handshake: msg_byte with byte_present,
//   and last_of_message to close the message. A request with no byte and
//   the last mark closes an empty tail.
//   out_rsp returns the eight digest words, word 0 first, last_word on 7.
// Timing:
//   Bytes are taken one per cycle while the block is idle. The 64th byte
//   of a block starts a compression (the buffer read states LOAD0 and
//   LOAD1, 64 rounds, one chaining add), during which no request is taken;
//   the rounds run at one per cycle and read the block buffer memory one
//   word per cycle. A closing request adds the padding bytes, one or two
//   compressions and the eight digest words.
// Reset:
//   Restores the initial hash value, clears fill and length; the block
//   buffer is not cleared. After the last digest word the block returns to
//   that state.
// Stall:
//   A held digest word blocks everything; no request is taken until all
//   eight words are delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
  input  logic             clk,
  input  logic             rst_n,
  msh_in_if.sink           in_req,
  msh_out_if.source        out_rsp
);
  import msh_pkg::*;

  state_t      state_r;
  state_t      state_nxt;
  pad_t        pad_r;
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic        closing_r;
  logic [5:0]  round_r;
  logic [2:0]  oidx_r;
  vars_t       chain_r;
  vars_t       vars_r;
  vars_t       vars_nxt;
  word_t       sched_r [16];
  word_t       wr_r;
  word_t       w_calc;
  word_t       rdata_r;
  word_t       buf_mem [16];
  taps_t       taps;

  logic        in_ready;
  logic        in_fire;
  logic        out_fire;
  logic        buf_we;
  logic [7:0]  wbyte;
  logic [3:0]  raddr;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic        digest_done;

  assign in_fire     = in_req.valid && in_ready;
  assign out_fire    = out_rsp.valid && out_rsp.ready;
  assign digest_done = out_fire && (oidx_r == LAST_WORD_NUM);
  assign len_bits    = {len_r, 3'b000};
  assign len_byte    = len_bits[{~fill_r[2:0], 3'b000} +: 8];

  assign in_req.ready        = in_ready;
  assign out_rsp.valid       = (state_r == ST_OUT);
  assign out_rsp.digest_word = chain_r[oidx_r];
  assign out_rsp.word_number = oidx_r;
  assign out_rsp.last_word   = (oidx_r == LAST_WORD_NUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    buf_we    = 1'b0;
    wbyte     = in_req.msg_byte;
    raddr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          buf_we = in_req.byte_present;
          if (in_req.byte_present && fill_r == LAST_SLOT) begin
            state_nxt = ST_LOAD0;
          end else if (in_req.last_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        buf_we = 1'b1;
        unique case (pad_r)
          PAD_MARK: wbyte = PAD_MARK_BYTE;
          PAD_ZERO: wbyte = (fill_r == LEN_START) ? len_byte : 8'h00;
          PAD_LEN:  wbyte = len_byte;
          default:  wbyte = 8'h00;
        endcase
        if (fill_r == LAST_SLOT) begin
          state_nxt = ST_LOAD0;
        end
      end
      ST_LOAD0: begin
        raddr     = 4'd0;
        state_nxt = ST_LOAD1;
      end
      ST_LOAD1: begin
        raddr     = 4'd1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        raddr = 4'(round_r + 6'd2);
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!closing_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_r == PAD_LEN) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (digest_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // block buffer: big-endian byte lanes of 16 words
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= wbyte;
    end
    rdata_r <= buf_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      len_r     <= '0;
      closing_r <= 1'b0;
      pad_r     <= PAD_MARK;
      round_r   <= '0;
      oidx_r    <= '0;
      chain_r   <= INIT_HASH;
    end else begin
      if (buf_we) begin
        fill_r <= fill_r + 6'd1;
      end
      if (in_fire && in_req.byte_present) begin
        len_r <= len_r + 61'd1;
      end
      if (in_fire && in_req.last_of_message) begin
        closing_r <= 1'b1;
        pad_r     <= PAD_MARK;
      end
      if (state_r == ST_PAD) begin
        unique case (pad_r)
          PAD_MARK: pad_r <= PAD_ZERO;
          PAD_ZERO: if (fill_r == LEN_START) pad_r <= PAD_LEN;
          PAD_LEN:  pad_r <= PAD_LEN;
          default:  pad_r <= PAD_MARK;
        endcase
      end
      if (state_r == ST_LOAD1) begin
        round_r <= '0;
      end else if (state_r == ST_ROUND) begin
        round_r <= round_r + 6'd1;
      end
      if (state_r == ST_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + vars_r[i];
        end
      end
      if (out_fire) begin
        oidx_r <= oidx_r + 3'd1;
      end
      if (digest_done) begin
        chain_r   <= INIT_HASH;
        fill_r    <= '0;
        len_r     <= '0;
        closing_r <= 1'b0;
      end
    end
  end

  // round datapath
  assign taps.w1  = sched_r[1];
  assign taps.w2  = sched_r[2];
  assign taps.w10 = sched_r[10];
  assign taps.w15 = sched_r[15];

  msh_round u_round (
    .vars_i  (vars_r),
    .w_i     (wr_r),
    .round_i (round_r),
    .taps_i  (taps),
    .vars_o  (vars_nxt),
    .w_o     (w_calc)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD1) begin
      vars_r <= chain_r;
      wr_r   <= rdata_r;
    end else if (state_r == ST_ROUND) begin
      vars_r <= vars_nxt;
      wr_r   <= (round_r < LAST_LOADED) ? rdata_r : w_calc;
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= wr_r;
    end
  end

  property p_rounds_run;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_ROUND && round_r != LAST_ROUND) |=> (state_r == ST_ROUND);
  endproperty
  a_rounds_run: assert property (p_rounds_run) else $error("round sequence broken");

  property p_load_empty;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_LOAD0) |-> (fill_r == 6'd0);
  endproperty
  a_load_empty: assert property (p_load_empty) else $error("compression on partial block");

  property p_len_slots;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_PAD && pad_r == PAD_LEN) |-> (fill_r[5:3] == 3'b111);
  endproperty
  a_len_slots: assert property (p_len_slots) else $error("length bytes misplaced");

  property p_digest_start;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_FINAL && closing_r && pad_r == PAD_LEN)
        |=> (state_r == ST_OUT && oidx_r == 3'd0);
  endproperty
  a_digest_start: assert property (p_digest_start) else $error("digest not started at word 0");

  property p_digest_clear;
    @(posedge clk) disable iff (!rst_n)
      digest_done |=> (fill_r == 6'd0 && len_r == 61'd0 && !closing_r);
  endproperty
  a_digest_clear: assert property (p_digest_clear) else $error("message state not cleared");

endmodule

`default_nettype wire
